>>> sv/tfr_pkg.sv
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types and constants for the transport frame reassembler.
// ----------------------------------------------------------------------------
package tfr_pkg;

    localparam int LEN_W    = 12;
    localparam int ID_W     = 11;
    localparam int SEQ_W    = 4;
    localparam int CNT_W    = 4;
    localparam int NWR_W    = 3;
    localparam int NRES_W   = 4;

    localparam logic [LEN_W-1:0] MAX_SIZE_RESET = 12'd256;
    localparam logic [ID_W-1:0]  REPLY_ID_RESET = 11'h125;

    localparam logic [CNT_W-1:0] FRAME_BYTES   = 4'd8;
    localparam logic [7:0]       FC_FIRST_BYTE = 8'h30;

    // frame type codes (high nibble of data0)
    localparam logic [3:0] PCI_SINGLE      = 4'h0;
    localparam logic [3:0] PCI_FIRST       = 4'h1;
    localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_FLOW  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // configuration register indexes
    localparam logic REG_MAX_SIZE = 1'b0;
    localparam logic REG_REPLY_ID = 1'b1;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_FLOW,
        TAIL_DONE
    } tail_t;

    typedef struct packed {
        logic             waiting;
        logic [LEN_W-1:0] msg_len;
        logic [LEN_W-1:0] bytes_so_far;
        logic [SEQ_W-1:0] exp_seq;
    } rx_state_t;

    typedef struct packed {
        logic [7:0][7:0]  data;
        logic [NWR_W-1:0] n_writes;
        logic [LEN_W-1:0] base;
        tail_t            tail;
        logic [LEN_W-1:0] total;
        logic [ID_W-1:0]  fid;
    } job_t;

endpackage

>>> sv/tfr_decode.sv
// ----------------------------------------------------------------------------
// tfr_decode
// Classifies one received frame against the reassembly state and produces
// the result job for the frame together with the next reassembly state.
// ----------------------------------------------------------------------------
module tfr_decode (
    input  logic [tfr_pkg::CNT_W-1:0] byte_count,
    input  logic [7:0][7:0]           data,
    input  tfr_pkg::rx_state_t        state,
    input  logic [tfr_pkg::LEN_W-1:0] max_size,
    input  logic [tfr_pkg::ID_W-1:0]  reply_id,
    output tfr_pkg::job_t             job,
    output logic                      job_valid,
    output tfr_pkg::rx_state_t        state_next
);

    logic [tfr_pkg::CNT_W-1:0] cnt;
    logic [3:0]                pci;
    logic [3:0]                low;
    logic [tfr_pkg::LEN_W-1:0] ff_total;
    logic [tfr_pkg::CNT_W-1:0] cf_copy_raw;
    logic [tfr_pkg::LEN_W-1:0] remain;
    logic [tfr_pkg::NWR_W-1:0] cf_copy;
    logic [tfr_pkg::LEN_W-1:0] bsf_next;
    logic [7:0][7:0]           data_from1;
    logic [7:0][7:0]           data_from2;

    assign cnt         = (byte_count > tfr_pkg::FRAME_BYTES) ? tfr_pkg::FRAME_BYTES : byte_count;
    assign pci         = data[0][7:4];
    assign low         = data[0][3:0];
    assign ff_total    = {low, data[1]};
    assign cf_copy_raw = (cnt != '0) ? cnt - 4'd1 : '0;
    assign remain      = (state.msg_len > state.bytes_so_far)
                         ? state.msg_len - state.bytes_so_far : '0;
    assign cf_copy     = ({8'd0, cf_copy_raw} > remain) ? remain[tfr_pkg::NWR_W-1:0]
                                                        : cf_copy_raw[tfr_pkg::NWR_W-1:0];
    assign bsf_next    = state.bytes_so_far + {9'd0, cf_copy};
    assign data_from1  = {8'h00, data[7:1]};
    assign data_from2  = {16'h0000, data[7:2]};

    always_comb begin
        state_next = state;
        job_valid  = 1'b0;
        job.data     = data_from1;
        job.n_writes = '0;
        job.base     = '0;
        job.tail     = tfr_pkg::TAIL_NONE;
        job.total    = '0;
        job.fid      = reply_id;

        if (!state.waiting) begin
            if (pci == tfr_pkg::PCI_SINGLE) begin
                if (low != 4'd0 && low < 4'd8) begin
                    job_valid          = 1'b1;
                    job.n_writes       = low[tfr_pkg::NWR_W-1:0];
                    job.tail           = tfr_pkg::TAIL_DONE;
                    job.total          = {8'd0, low};
                    state_next.msg_len = {8'd0, low};
                end
            end else if (pci == tfr_pkg::PCI_FIRST) begin
                if (cnt == tfr_pkg::FRAME_BYTES && ff_total >= 12'd8
                        && ff_total <= max_size) begin
                    job_valid               = 1'b1;
                    job.data                = data_from2;
                    job.n_writes            = 3'd6;
                    job.tail                = tfr_pkg::TAIL_FLOW;
                    state_next.msg_len      = ff_total;
                    state_next.bytes_so_far = 12'd6;
                    state_next.exp_seq      = 4'd1;
                    state_next.waiting      = 1'b1;
                end
            end
        end else begin
            if (pci == tfr_pkg::PCI_CONSECUTIVE && low == state.exp_seq) begin
                job.n_writes            = cf_copy;
                job.base                = state.bytes_so_far;
                state_next.bytes_so_far = bsf_next;
                state_next.exp_seq      = state.exp_seq + 4'd1;
                job_valid               = (cf_copy != '0);
                if (bsf_next >= state.msg_len) begin
                    job.tail           = tfr_pkg::TAIL_DONE;
                    job.total          = state.msg_len;
                    job_valid          = 1'b1;
                    state_next.waiting = 1'b0;
                end
            end else begin
                state_next.waiting = 1'b0;
            end
        end
    end

endmodule

>>> sv/transport_frame_reassembler_core.sv
// ----------------------------------------------------------------------------
// transport_frame_reassembler_core
// Receive-side reassembler for segmented transport messages over CAN frames.
// ----------------------------------------------------------------------------
// One frame enters per input transaction and is decoded in that cycle; its
// results (payload byte writes, flow control request, completion), one to
// eight per frame, then leave one per cycle through an output register while
// the output is not stalled. The next frame is taken in the same cycle as the
// final result of the previous one moves to the output register, so frames
// follow each other without a gap.
module transport_frame_reassembler_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [11:0] cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    // byte_count[3:0], data0[11:4], data1 .. data7 in following bytes up to [67:60]
    input  logic [71:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // offset[11:0], value[19:12], total_length[31:20], frame_id[42:32]
    output logic [47:0] m_tdata,
    // kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic [tfr_pkg::LEN_W-1:0]  max_size_reg;
    logic [tfr_pkg::ID_W-1:0]   reply_id_reg;
    tfr_pkg::rx_state_t         state_reg;
    tfr_pkg::rx_state_t         state_next;

    tfr_pkg::job_t              job_reg;
    tfr_pkg::job_t              job_new;
    logic                       job_new_valid;
    logic                       job_valid_reg;
    logic [tfr_pkg::NWR_W-1:0]  idx_reg;

    logic                       m_valid_reg;
    logic [1:0]                 m_kind_reg;
    logic [tfr_pkg::LEN_W-1:0]  m_offset_reg;
    logic [7:0]                 m_value_reg;
    logic [tfr_pkg::LEN_W-1:0]  m_total_reg;
    logic [tfr_pkg::ID_W-1:0]   m_fid_reg;
    logic                       m_last_reg;

    logic [7:0][7:0]            in_data;
    logic                       s_accept;
    logic                       out_free;
    logic                       emit;
    logic [tfr_pkg::NRES_W-1:0] n_res;
    logic                       cur_last;
    logic                       cur_is_write;
    logic [1:0]                 cur_kind;
    logic [tfr_pkg::LEN_W-1:0]  cur_offset;
    logic [7:0]                 cur_value;
    logic [tfr_pkg::LEN_W-1:0]  cur_total;
    logic [tfr_pkg::ID_W-1:0]   cur_fid;

    assign in_data = s_tdata[67:4];

    tfr_decode u_decode (
        .byte_count (s_tdata[3:0]),
        .data       (in_data),
        .state      (state_reg),
        .max_size   (max_size_reg),
        .reply_id   (reply_id_reg),
        .job        (job_new),
        .job_valid  (job_new_valid),
        .state_next (state_next)
    );

    assign n_res = {1'b0, job_reg.n_writes}
                 + ((job_reg.tail != tfr_pkg::TAIL_NONE) ? 4'd1 : 4'd0);
    assign cur_last     = ({1'b0, idx_reg} + 4'd1) == n_res;
    assign cur_is_write = idx_reg < job_reg.n_writes;
    assign out_free     = !m_valid_reg || m_tready;
    assign emit         = job_valid_reg && out_free;
    assign s_tready     = !job_valid_reg || (emit && cur_last);
    assign s_accept     = s_tvalid && s_tready;

    always_comb begin
        cur_kind   = tfr_pkg::KIND_WRITE;
        cur_offset = '0;
        cur_value  = '0;
        cur_total  = '0;
        cur_fid    = '0;
        if (cur_is_write) begin
            cur_offset = job_reg.base + {9'd0, idx_reg};
            cur_value  = job_reg.data[idx_reg];
        end else begin
            unique case (job_reg.tail)
                tfr_pkg::TAIL_FLOW: begin
                    cur_kind  = tfr_pkg::KIND_FLOW;
                    cur_value = tfr_pkg::FC_FIRST_BYTE;
                    cur_fid   = job_reg.fid;
                end
                tfr_pkg::TAIL_DONE: begin
                    cur_kind  = tfr_pkg::KIND_DONE;
                    cur_total = job_reg.total;
                end
                default: begin
                    cur_kind = tfr_pkg::KIND_WRITE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg <= tfr_pkg::MAX_SIZE_RESET;
            reply_id_reg <= tfr_pkg::REPLY_ID_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                tfr_pkg::REG_MAX_SIZE: max_size_reg <= cfg_wr_data;
                tfr_pkg::REG_REPLY_ID: reply_id_reg <= cfg_wr_data[tfr_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept) begin
                job_valid_reg <= job_new_valid;
                idx_reg       <= '0;
            end else if (emit) begin
                if (cur_last) begin
                    job_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            job_reg <= job_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_kind_reg   <= cur_kind;
            m_offset_reg <= cur_offset;
            m_value_reg  <= cur_value;
            m_total_reg  <= cur_total;
            m_fid_reg    <= cur_fid;
            m_last_reg   <= cur_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_fid_reg, m_total_reg, m_value_reg, m_offset_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for transport_frame_reassembler_core. Frames go in
// through the stream input; a scoreboard decodes each accepted frame into the
// byte writes, flow control requests and completions it must cause. Every
// output transaction is then checked against the oldest of those. A directed
// set of corner cases comes first. Randomized message traffic follows under
// four register settings, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [3:0]  PCI_FLOW_CONTROL = 4'h3;
    localparam int          SETTLE_CYCLES    = 24;
    localparam int          LONG_HOLD        = 300;
    localparam int unsigned CYCLE_LIMIT      = 400000;

    typedef struct packed {
        logic [1:0]                kind;
        logic [tfr_pkg::LEN_W-1:0] offset;
        logic [7:0]                value;
        logic [tfr_pkg::LEN_W-1:0] total;
        logic [tfr_pkg::ID_W-1:0]  fid;
        logic                      last;
    } reassembly_result_t;

    class message_scoreboard;
        reassembly_result_t        pending_results[$];
        int                        errors;
        logic [tfr_pkg::LEN_W-1:0] max_size;
        logic [tfr_pkg::ID_W-1:0]  reply_id;
        logic                      waiting;
        logic [tfr_pkg::LEN_W-1:0] msg_len;
        logic [tfr_pkg::LEN_W-1:0] so_far;
        logic [tfr_pkg::SEQ_W-1:0] exp_seq;

        function new();
            errors   = 0;
            max_size = tfr_pkg::MAX_SIZE_RESET;
            reply_id = tfr_pkg::REPLY_ID_RESET;
            waiting  = 1'b0;
            msg_len  = '0;
            so_far   = '0;
            exp_seq  = '0;
        endfunction

        function void set_register(logic idx, logic [11:0] value);
            if (idx == tfr_pkg::REG_MAX_SIZE) begin
                max_size = value;
            end else begin
                reply_id = value[tfr_pkg::ID_W-1:0];
            end
        endfunction

        function void add_result(logic [1:0] kind, logic [tfr_pkg::LEN_W-1:0] offset,
                                 logic [7:0] value, logic [tfr_pkg::LEN_W-1:0] total,
                                 logic [tfr_pkg::ID_W-1:0] fid);
            reassembly_result_t r;
            r.kind   = kind;
            r.offset = offset;
            r.value  = value;
            r.total  = total;
            r.fid    = fid;
            r.last   = 1'b0;
            pending_results.push_back(r);
        endfunction

        // decode one accepted frame into the results it must cause
        function void note_frame(logic [3:0] count_in, logic [7:0][7:0] fb);
            logic [3:0]                cnt;
            logic [3:0]                pci;
            logic [3:0]                low;
            logic [tfr_pkg::LEN_W-1:0] total;
            int                        copy;
            int                        remain;
            int                        i;
            int                        first;
            first = pending_results.size();
            cnt   = (count_in > tfr_pkg::FRAME_BYTES) ? tfr_pkg::FRAME_BYTES : count_in;
            pci   = fb[0][7:4];
            low   = fb[0][3:0];
            if (!waiting) begin
                if (pci == tfr_pkg::PCI_SINGLE) begin
                    if (low > 0 && low < 8) begin
                        for (i = 0; i < low; i++)
                            add_result(tfr_pkg::KIND_WRITE, 12'(i), fb[1+i], '0, '0);
                        msg_len = {8'd0, low};
                        add_result(tfr_pkg::KIND_DONE, '0, '0, {8'd0, low}, '0);
                    end
                end else if (pci == tfr_pkg::PCI_FIRST) begin
                    total = {low, fb[1]};
                    if (cnt >= tfr_pkg::FRAME_BYTES && total >= 8 && total <= max_size) begin
                        for (i = 0; i < 6; i++)
                            add_result(tfr_pkg::KIND_WRITE, 12'(i), fb[2+i], '0, '0);
                        add_result(tfr_pkg::KIND_FLOW, '0, tfr_pkg::FC_FIRST_BYTE, '0,
                                   reply_id);
                        msg_len = total;
                        so_far  = 12'd6;
                        exp_seq = 4'd1;
                        waiting = 1'b1;
                    end
                end
            end else if (pci == tfr_pkg::PCI_CONSECUTIVE && low == exp_seq) begin
                copy   = (cnt > 0) ? cnt - 1 : 0;
                remain = (msg_len > so_far) ? msg_len - so_far : 0;
                if (copy > remain)
                    copy = remain;
                for (i = 0; i < copy; i++)
                    add_result(tfr_pkg::KIND_WRITE, so_far + 12'(i), fb[1+i], '0, '0);
                so_far  = so_far + 12'(copy);
                exp_seq = exp_seq + 4'd1;
                if (so_far >= msg_len) begin
                    add_result(tfr_pkg::KIND_DONE, '0, '0, msg_len, '0);
                    waiting = 1'b0;
                end
            end else begin
                waiting = 1'b0;
            end
            if (pending_results.size() > first)
                pending_results[pending_results.size()-1].last = 1'b1;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 50)
                $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_result(logic [1:0] kind, logic [tfr_pkg::LEN_W-1:0] offset,
                          logic [7:0] value, logic [tfr_pkg::LEN_W-1:0] total,
                          logic [tfr_pkg::ID_W-1:0] fid, logic last);
            reassembly_result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected transaction kind %0d offset %0d", kind, offset));
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind)
                report($sformatf("kind %0d, want %0d", kind, want.kind));
            if (offset !== want.offset)
                report($sformatf("offset %0d, want %0d", offset, want.offset));
            if (value !== want.value)
                report($sformatf("value %h, want %h", value, want.value));
            if (total !== want.total)
                report($sformatf("total_length %0d, want %0d", total, want.total));
            if (fid !== want.fid)
                report($sformatf("frame_id %h, want %h", fid, want.fid));
            if (last !== want.last)
                report($sformatf("tlast %b, want %b", last, want.last));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_index;
    logic [11:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    message_scoreboard sb;
    int               frames_accepted = 0;
    int               burst_left = 0;
    int               hold_request = 0;
    int               cur_max = tfr_pkg::MAX_SIZE_RESET;
    int               rx_mode = 0;
    int               rx_span = 0;
    int unsigned      cycle_count = 0;

    transport_frame_reassembler_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[11:0], m_tdata[19:12], m_tdata[31:20],
                            m_tdata[42:32], m_tlast);
    end

    // output side: random stall modes, plus one long hold-off
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_span = $urandom_range(20, 150);
            end
            rx_span--;
            case (rx_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= ~m_tready;
                end
            endcase
        end
    end

    function automatic logic [7:0][7:0] build_frame(logic [3:0] pci, logic [3:0] low,
                                                    logic [55:0] rest);
        return {rest, pci, low};
    endfunction

    function automatic logic [7:0][7:0] random_frame();
        return {$urandom, $urandom};
    endfunction

    task automatic send_frame(input logic [3:0] cnt, input logic [7:0][7:0] fb);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {4'h0, fb, cnt};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_frame(cnt, fb);
        frames_accepted++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic reconfigure(input int max_size, input int reply_id);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= tfr_pkg::REG_MAX_SIZE;
        cfg_wr_data  <= 12'(max_size);
        @(posedge aclk);
        sb.set_register(tfr_pkg::REG_MAX_SIZE, 12'(max_size));
        cfg_wr_index <= tfr_pkg::REG_REPLY_ID;
        cfg_wr_data  <= 12'(reply_id);
        @(posedge aclk);
        sb.set_register(tfr_pkg::REG_REPLY_ID, 12'(reply_id));
        cfg_wr_en <= 1'b0;
        cur_max = max_size;
    endtask

    // first frame then consecutive frames, now and then cut short or broken
    task automatic send_message(input int total);
        logic [7:0][7:0] fb;
        logic [3:0]      cnt;
        logic [3:0]      seq;
        int              left;
        int              r;
        int              copy;
        bit              broken;
        fb    = random_frame();
        fb[0] = {tfr_pkg::PCI_FIRST, 4'(total >> 8)};
        fb[1] = 8'(total);
        r     = $urandom_range(0, 99);
        cnt   = (r < 85) ? 4'd8 : (r < 95) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 7));
        send_frame(cnt, fb);
        left   = total - 6;
        seq    = 4'd1;
        broken = 1'b0;
        while (left > 0 && !broken) begin
            fb    = random_frame();
            fb[0] = {tfr_pkg::PCI_CONSECUTIVE, seq};
            r     = $urandom_range(0, 99);
            if (r < 5)
                cnt = 4'($urandom_range(0, 1));
            else if (r < 10)
                cnt = 4'($urandom_range(9, 15));
            else if (r < 20)
                cnt = 4'($urandom_range(2, 8));
            else if (left < 7 && $urandom_range(0, 1) == 0)
                cnt = 4'(left + 1);
            else
                cnt = 4'd8;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                fb[0][3:0] = seq + 4'($urandom_range(1, 15));
                broken = 1'b1;
            end else if (r < 5) begin
                fb[0][7:4] = 4'($urandom_range(3, 17) % 16);
                broken = 1'b1;
            end
            send_frame(cnt, fb);
            copy = (cnt > 8) ? 7 : (cnt > 0) ? cnt - 1 : 0;
            left -= copy;
            seq = seq + 4'd1;
        end
    endtask

    task automatic run_random(input int target);
        logic [7:0][7:0] fb;
        int              r;
        int              cap;
        int              total;
        int              over;
        while (frames_accepted < target) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                r = $urandom_range(0, 99);
                cap = (cur_max < 300) ? cur_max : 300;
                over = (4095 - cur_max < 20) ? 4095 - cur_max : 20;
                if (r < 8)
                    total = $urandom_range(0, 7);
                else if (r < 14)
                    total = (over <= 0) ? cap : cur_max + $urandom_range(1, over);
                else if (r < 18)
                    total = cap;
                else if (r < 28)
                    total = $urandom_range(8, cap);
                else
                    total = $urandom_range(8, (cap < 48) ? cap : 48);
                send_message(total);
            end else if (r < 80) begin
                fb    = random_frame();
                fb[0] = {tfr_pkg::PCI_SINGLE,
                         ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(1, 7))};
                send_frame(4'($urandom_range(0, 15)), fb);
            end else begin
                send_frame(4'($urandom_range(0, 15)), random_frame());
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= tfr_pkg::REG_MAX_SIZE;
        cfg_wr_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single frames
        send_frame(4'd2,  build_frame(tfr_pkg::PCI_SINGLE, 4'd1, 56'hA5));
        send_frame(4'd0,  build_frame(tfr_pkg::PCI_SINGLE, 4'd7, {56{1'b1}}));
        send_frame(4'd8,  build_frame(tfr_pkg::PCI_SINGLE, 4'd0, 56'h11_2233_4455_6677));
        send_frame(4'd8,  build_frame(tfr_pkg::PCI_SINGLE, 4'd8, 56'h11_2233_4455_6677));
        send_frame(4'd15, build_frame(tfr_pkg::PCI_SINGLE, 4'd3, 56'h00_0000_00C3_B200));
        // first frames that must be dropped, stray frames while idle
        send_frame(4'd8, build_frame(tfr_pkg::PCI_FIRST, 4'd0, {48'hDEAD_BEEF_0001, 8'd7}));
        send_frame(4'd8, build_frame(tfr_pkg::PCI_FIRST, 4'd1, {48'h0102_0304_0506, 8'd1}));
        send_frame(4'd7, build_frame(tfr_pkg::PCI_FIRST, 4'd0, {48'h0102_0304_0506, 8'd20}));
        send_frame(4'd8, build_frame(tfr_pkg::PCI_CONSECUTIVE, 4'd1, 56'h77_6655_4433_2211));
        send_frame(4'd8, build_frame(PCI_FLOW_CONTROL, 4'd0, 56'h0));
        // shortest message; empty consecutive frames, then one over the remainder
        send_frame(4'd8, build_frame(tfr_pkg::PCI_FIRST, 4'd0, {48'hFFEE_DDCC_BBAA, 8'd8}));
        send_frame(4'd0, build_frame(tfr_pkg::PCI_CONSECUTIVE, 4'd1, 56'h12_3456_789A_BCDE));
        send_frame(4'd1, build_frame(tfr_pkg::PCI_CONSECUTIVE, 4'd2, 56'h12_3456_789A_BCDE));
        send_frame(4'd8, build_frame(tfr_pkg::PCI_CONSECUTIVE, 4'd3, 56'hFF_0000_0000_00FF));
        // out-of-order sequence drops the message
        send_frame(4'd8, build_frame(tfr_pkg::PCI_FIRST, 4'd0, {48'h0, 8'd20}));
        send_frame(4'd8, build_frame(tfr_pkg::PCI_CONSECUTIVE, 4'd1, 56'h01_0203_0405_0607));
        send_frame(4'd8, build_frame(tfr_pkg::PCI_CONSECUTIVE, 4'd3, 56'h01_0203_0405_0607));
        send_frame(4'd8, build_frame(tfr_pkg::PCI_CONSECUTIVE, 4'd2, 56'h01_0203_0405_0607));
        // single frame while waiting drops the message and is not decoded
        send_frame(4'd8, build_frame(tfr_pkg::PCI_FIRST, 4'd0, {48'h0, 8'd20}));
        send_frame(4'd3, build_frame(tfr_pkg::PCI_SINGLE, 4'd2, 56'hAB_CDEF));
        // oversized byte counts clamp to eight
        send_frame(4'd12, build_frame(tfr_pkg::PCI_FIRST, 4'd0, {48'h8877_6655_4433, 8'd14}));
        send_frame(4'd15, build_frame(tfr_pkg::PCI_CONSECUTIVE, 4'd1, 56'hF0_E1D2_C3B4_A596));
        send_frame(4'd8,  build_frame(tfr_pkg::PCI_CONSECUTIVE, 4'd2, 56'h00_0000_0000_0080));

        run_random(frames_accepted + 50);
        hold_request = LONG_HOLD;
        run_random(frames_accepted + 70);

        reconfigure(8, 0);
        run_random(frames_accepted + 60);

        reconfigure(4095, 2047);
        run_random(frames_accepted + 60);
        wait_results_drained();
        run_random(frames_accepted + 60);

        reconfigure($urandom_range(9, 300), $urandom_range(1, 2046));
        run_random(frames_accepted + 120);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
